// ===== sv/psr_pkg.sv =====
`default_nettype none

package psr_pkg;

    localparam int POSITION_WIDTH_DEF = 32;
    localparam int FRACTION_BITS_DEF  = 16;

    localparam int DECEL_BITS = 16;
    localparam int FRAC_W     = DECEL_BITS + 1;

    localparam logic [FRAC_W-1:0] DECEL_ONE   = FRAC_W'(1 << DECEL_BITS);
    localparam logic [FRAC_W-1:0] DECEL_RESET = FRAC_W'(13107);
    localparam int ARRIVE_TOLERANCE_RESET     = 3277;

    localparam int MIN_STEP_DIVISOR = 50;

    localparam logic OP_START = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    localparam logic [0:0] CFG_DECEL_FRACTION   = 1'b0;
    localparam logic [0:0] CFG_ARRIVE_TOLERANCE = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } t_md_stat;

endpackage

`default_nettype wire

// ===== sv/psr_mul_div.sv =====
`default_nettype none

module psr_mul_div #(
    parameter int POSITION_WIDTH = psr_pkg::POSITION_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [POSITION_WIDTH-2:0] i_multiplicand,
    input  logic [POSITION_WIDTH:0]   i_multiplier,
    input  logic [POSITION_WIDTH:0]   i_divisor,
    output psr_pkg::t_md_stat         o_stat,
    output logic [POSITION_WIDTH-2:0] o_quotient
);
    import psr_pkg::*;

    localparam int A_W   = POSITION_WIDTH - 1;
    localparam int D_W   = POSITION_WIDTH + 1;
    localparam int S_W   = D_W + 2;
    localparam int CNT_W = $clog2(A_W);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(A_W - 1);

    logic [A_W-1:0]   r_a;
    logic [D_W-1:0]   r_b;
    logic [D_W-1:0]   r_d;
    logic [D_W-1:0]   r_rem;
    logic [A_W-1:0]   r_q;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [S_W-1:0] w_sum;
    logic [S_W-1:0] w_d1;
    logic [S_W-1:0] w_d2;
    logic [D_W-1:0] n_rem;
    logic [1:0]     w_k;

    // one digit of the multiplicand: remainder doubles, multiplier added, up to two divisors off
    assign w_sum = S_W'({r_rem, 1'b0}) + (r_a[A_W-1] ? S_W'(r_b) : '0);
    assign w_d1  = S_W'(r_d);
    assign w_d2  = S_W'({r_d, 1'b0});

    always_comb begin
        if (w_sum >= w_d2) begin
            w_k   = 2'd2;
            n_rem = D_W'(w_sum - w_d2);
        end else if (w_sum >= w_d1) begin
            w_k   = 2'd1;
            n_rem = D_W'(w_sum - w_d1);
        end else begin
            w_k   = 2'd0;
            n_rem = D_W'(w_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a    <= i_multiplicand;
                r_b    <= i_multiplier;
                r_d    <= i_divisor;
                r_rem  <= '0;
                r_q    <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_a   <= {r_a[A_W-2:0], 1'b0};
                r_rem <= n_rem;
                r_q   <= {r_q[A_W-2:0], 1'b0} + A_W'(w_k);
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_q;

endmodule

`default_nettype wire

// ===== sv/position_setpoint_ramp.sv =====
`default_nettype none

// channel   direction  handshake                    payload
// in        sink       i_in_valid / o_in_ready      i_op, i_aim_position, i_current_position,
//                                                   i_step_size, i_setpoint_offset
// out       source     o_out_valid / i_out_ready    o_target_position, o_commanded_position,
//                                                   o_arrived
// cfg       sink       i_cfg_wr_en                  i_cfg_index, i_cfg_data
//
// a start beat runs S_SUM, S_EMIT; a tick S_PREP, S_SCALE, S_CHECK, S_MOVE, S_SUM, S_EMIT,
// plus S_DIV1 and S_DIV2 when it decelerates: the shared multiply-divide unit runs once
// for the proportional step and once for the 2% floor, one multiplicand bit per cycle
// synchronous active-low reset clears aim, target and travel and reloads both registers
// o_in_ready rises in the same cycle as o_out_valid; a pending result does not block it
// a held result stalls the sequencer in its last state until the output register frees

module position_setpoint_ramp #(
    parameter int POSITION_WIDTH = psr_pkg::POSITION_WIDTH_DEF,
    parameter int FRACTION_BITS  = psr_pkg::FRACTION_BITS_DEF,
    parameter int CFG_W          = (POSITION_WIDTH - 1 > psr_pkg::FRAC_W) ?
                                   POSITION_WIDTH - 1 : psr_pkg::FRAC_W
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic                             i_op,
    input  logic signed [POSITION_WIDTH-1:0] i_aim_position,
    input  logic signed [POSITION_WIDTH-1:0] i_current_position,
    input  logic        [POSITION_WIDTH-2:0] i_step_size,
    input  logic signed [POSITION_WIDTH-1:0] i_setpoint_offset,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic signed [POSITION_WIDTH-1:0] o_target_position,
    output logic signed [POSITION_WIDTH-1:0] o_commanded_position,
    output logic                             o_arrived,
    input  logic                             i_cfg_wr_en,
    input  logic [0:0]                       i_cfg_index,
    input  logic [CFG_W-1:0]                 i_cfg_data
);
    import psr_pkg::*;

    localparam int P   = POSITION_WIDTH;
    localparam int A_W = P - 1;
    localparam int D_W = P + 1;
    localparam int M_W = FRAC_W + D_W;
    localparam logic [D_W-1:0] DECEL_FLOOR = D_W'((64'd1 << FRACTION_BITS) / 64'd1000000);
    localparam logic signed [P-1:0] POS_MAX = {1'b0, {(P-1){1'b1}}};
    localparam logic signed [P-1:0] POS_MIN = {1'b1, {(P-1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_SCALE,
        S_CHECK,
        S_DIV1,
        S_DIV2,
        S_MOVE,
        S_SUM,
        S_EMIT
    } t_state;

    t_state r_state;

    logic signed [P-1:0]   r_aim;
    logic signed [P-1:0]   r_target;
    logic signed [D_W-1:0] r_travel;
    logic [FRAC_W-1:0]     r_decel;
    logic [A_W-1:0]        r_tol;

    logic signed [P-1:0]   r_cur;
    logic [A_W-1:0]        r_step;
    logic signed [P-1:0]   r_offset;

    logic [D_W-1:0]        r_trav_mag;
    logic signed [D_W-1:0] r_diff;
    logic [D_W-1:0]        r_dist;
    logic [D_W-1:0]        r_rem;
    logic                  r_up;
    logic [A_W-1:0]        r_eff;
    logic signed [D_W-1:0] r_sum;
    logic signed [D_W-1:0] r_gap;

    logic                  r_out_valid;
    logic signed [P-1:0]   r_out_target;
    logic signed [P-1:0]   r_out_cmd;
    logic                  r_out_arrived;

    logic                  w_in_beat;
    logic                  w_out_free;
    logic [FRAC_W-1:0]     w_frac;
    logic [M_W-1:0]        w_product;
    logic signed [D_W-1:0] w_travel_new;
    logic signed [D_W-1:0] w_eff_ext;
    logic signed [D_W-1:0] w_aim_ext;
    logic signed [D_W-1:0] w_up_sum;
    logic signed [D_W-1:0] w_dn_sum;
    logic signed [P-1:0]   w_next_target;
    logic signed [P-1:0]   w_cmd;
    logic signed [D_W-1:0] w_tol_ext;
    logic                  w_arrived;

    logic                  w_md_start;
    logic [D_W-1:0]        w_md_mult;
    logic [D_W-1:0]        w_md_div;
    t_md_stat              w_md_stat;
    logic [A_W-1:0]        w_md_q;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_beat  = i_in_valid && o_in_ready;
    assign w_out_free = !r_out_valid || i_out_ready;

    assign w_frac       = (r_decel > DECEL_ONE) ? DECEL_ONE : r_decel;
    assign w_product    = M_W'(w_frac) * M_W'(r_trav_mag);
    assign w_travel_new = D_W'(i_aim_position) - D_W'(i_current_position);

    assign w_eff_ext = $signed({2'b00, r_eff});
    assign w_aim_ext = D_W'(r_aim);
    assign w_up_sum  = D_W'(r_target) + w_eff_ext;
    assign w_dn_sum  = D_W'(r_target) - w_eff_ext;

    always_comb begin
        if (r_up) begin
            w_next_target = (w_up_sum > w_aim_ext) ? r_aim : w_up_sum[P-1:0];
        end else begin
            w_next_target = (w_dn_sum < w_aim_ext) ? r_aim : w_dn_sum[P-1:0];
        end
    end

    // saturate on overflow of the offset sum
    assign w_cmd     = (r_sum[P] != r_sum[P-1]) ? (r_sum[P] ? POS_MIN : POS_MAX)
                                                : r_sum[P-1:0];
    assign w_tol_ext = $signed({2'b00, r_tol});
    assign w_arrived = (r_gap < w_tol_ext) && (r_gap > -w_tol_ext);

    assign w_md_start = ((r_state == S_CHECK) && (r_dist > DECEL_FLOOR) && (r_rem < r_dist))
                     || ((r_state == S_DIV1) && w_md_stat.done);
    assign w_md_mult  = (r_state == S_DIV1) ? D_W'(1) : r_rem;
    assign w_md_div   = (r_state == S_DIV1) ? D_W'(MIN_STEP_DIVISOR) : r_dist;

    psr_mul_div #(
        .POSITION_WIDTH (POSITION_WIDTH)
    ) u_mul_div (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (w_md_start),
        .i_multiplicand (r_step),
        .i_multiplier   (w_md_mult),
        .i_divisor      (w_md_div),
        .o_stat         (w_md_stat),
        .o_quotient     (w_md_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_aim       <= '0;
            r_target    <= '0;
            r_travel    <= '0;
            r_decel     <= DECEL_RESET;
            r_tol       <= A_W'(ARRIVE_TOLERANCE_RESET);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                if (i_cfg_index == CFG_DECEL_FRACTION) begin
                    r_decel <= i_cfg_data[FRAC_W-1:0];
                end else begin
                    r_tol <= i_cfg_data[A_W-1:0];
                end
            end

            if (r_out_valid && i_out_ready && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_in_beat) begin
                        r_cur    <= i_current_position;
                        r_step   <= i_step_size;
                        r_offset <= i_setpoint_offset;
                        if (i_op == OP_START) begin
                            r_aim    <= i_aim_position;
                            r_target <= i_current_position;
                            r_travel <= w_travel_new;
                            r_state  <= S_SUM;
                        end else begin
                            r_state  <= S_PREP;
                        end
                    end
                end
                S_PREP: begin
                    r_trav_mag <= r_travel[P] ? D_W'(-r_travel) : D_W'(r_travel);
                    r_diff     <= D_W'(r_aim) - D_W'(r_target);
                    r_state    <= S_SCALE;
                end
                S_SCALE: begin
                    r_dist  <= w_product[DECEL_BITS+D_W-1:DECEL_BITS];
                    r_rem   <= r_diff[P] ? D_W'(-r_diff) : D_W'(r_diff);
                    r_up    <= !r_diff[P] && (r_diff != '0);
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if (w_md_start) begin
                        r_state <= S_DIV1;
                    end else begin
                        r_eff   <= r_step;
                        r_state <= S_MOVE;
                    end
                end
                S_DIV1: begin
                    if (w_md_stat.done) begin
                        r_eff   <= w_md_q;
                        r_state <= S_DIV2;
                    end
                end
                S_DIV2: begin
                    if (w_md_stat.done) begin
                        // never below the 2% floor
                        if (w_md_q > r_eff) begin
                            r_eff <= w_md_q;
                        end
                        r_state <= S_MOVE;
                    end
                end
                S_MOVE: begin
                    r_target <= w_next_target;
                    r_state  <= S_SUM;
                end
                S_SUM: begin
                    r_sum   <= D_W'(r_target) + D_W'(r_offset);
                    r_gap   <= D_W'(r_aim) - D_W'(r_cur);
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_out_free) begin
                        r_out_valid   <= 1'b1;
                        r_out_target  <= r_target;
                        r_out_cmd     <= w_cmd;
                        r_out_arrived <= w_arrived;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_target_position    = r_out_target;
    assign o_commanded_position = r_out_cmd;
    assign o_arrived            = r_out_arrived;

    a_idle_unit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !w_md_stat.busy)
        else $error("shared unit busy while idle");

    a_step_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_MOVE |-> r_eff <= r_step)
        else $error("effective step above nominal step");

    a_no_overshoot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOVE && r_up) |=> r_target <= r_aim)
        else $error("target passed the aim");

    a_result_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == S_EMIT)
        else $error("result loaded outside the final state");

    a_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_md_stat.done |-> (r_state == S_DIV1 || r_state == S_DIV2))
        else $error("unexpected completion from shared unit");

endmodule

`default_nettype wire
